[hw/rtl/bamc_pkg.sv]
// ---------------------------------------------------------------------------
// bamc_pkg
// Shared types, operation codes and elaboration helpers for the bit
// addressed memory copy block.
// ---------------------------------------------------------------------------
`default_nettype none

package bamc_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OP_W      = 2;
  localparam int IN_ADDR_W = 12;
  localparam int COUNT_W   = 13;

  // Width of the reduction step index.
  localparam int STEP_W    = 5;

  // Default store size in bits.
  localparam int STORE_BITS_DEF = 4096;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_COPY  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new request
    logic reduce;     // one compare-and-subtract step of the address wrap
    logic rd_issue;   // read the source and destination bytes
    logic wr_value;   // write the request's bit value
    logic wr_copy;    // write the source bit and step to the next bit
    logic finish;     // load the result register
  } bamc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            red_last;
    logic            cnt_zero;
    logic            cnt_one;
  } bamc_status_t;

  // Number of shifted multiples of the store size that fit in an input
  // address; this many compare-and-subtract steps reduce any input address.
  function automatic int red_steps(input int s);
    int n;
    longint thr;
    n = 0;
    for (int k = 0; k < 21; k++) begin
      thr = longint'(s) << k;
      if (thr <= longint'((1 << IN_ADDR_W) - 1)) n++;
    end
    return n;
  endfunction

  // Width of an internal bit address register.
  function automatic int addr_w(input int s);
    int w;
    w = $clog2(s);
    return (w > IN_ADDR_W) ? w : IN_ADDR_W;
  endfunction

  // Width of a byte index into the store.
  function automatic int byte_w(input int s);
    int d;
    d = (s + 7) / 8;
    return (d > 1) ? $clog2(d) : 1;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bamc_ram.sv]
// ---------------------------------------------------------------------------
// bamc_ram
// Generic RAM with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module bamc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 ra_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ra_addr,
  output logic      [WIDTH-1:0]                     ra_data,
  input  wire logic                                 rb_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rb_addr,
  output logic      [WIDTH-1:0]                     rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports; data holds while the port is not enabled.
  always_ff @(posedge clk) begin
    if (ra_en) begin
      ra_data <= mem[ra_addr];
    end
    if (rb_en) begin
      rb_data <= mem[rb_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bamc_datapath.sv]
// ---------------------------------------------------------------------------
// bamc_datapath
// Address, count and result registers plus the byte store, driven by the
// controller's commands.
// ---------------------------------------------------------------------------
`default_nettype none

module bamc_datapath #(
  parameter int STORE_BITS = bamc_pkg::STORE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire bamc_pkg::bamc_cmd_t            cmd,
  output bamc_pkg::bamc_status_t              status,
  input  wire logic [bamc_pkg::OP_W-1:0]      in_operation,
  input  wire logic [bamc_pkg::IN_ADDR_W-1:0] in_dest_addr,
  input  wire logic [bamc_pkg::IN_ADDR_W-1:0] in_src_addr,
  input  wire logic [bamc_pkg::COUNT_W-1:0]   in_bit_count,
  input  wire logic                           in_write_value,
  output logic                                out_read_bit,
  output logic [bamc_pkg::OP_W-1:0]           out_done_operation
);

  localparam int XW        = bamc_pkg::addr_w(STORE_BITS);
  localparam int BW        = bamc_pkg::byte_w(STORE_BITS);
  localparam int DEPTH     = (STORE_BITS + 7) / 8;
  localparam int RED_STEPS = bamc_pkg::red_steps(STORE_BITS);
  localparam int K_INIT    = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;

  logic [bamc_pkg::OP_W-1:0]    op_r;
  logic [XW-1:0]                src_r, src_nxt;
  logic [XW-1:0]                dst_r, dst_nxt;
  logic [bamc_pkg::COUNT_W-1:0] cnt_r;
  logic                         val_r;
  logic [bamc_pkg::STEP_W-1:0]  k_r;
  logic                         rd_bit_r;
  logic [bamc_pkg::OP_W-1:0]    rd_op_r;

  logic [XW-1:0] thr;
  logic [BW-1:0] src_byte, dst_byte;
  logic [7:0]    src_data, dst_data, wr_data, mask;
  logic          src_bit, new_bit;

  // Shifted store size for the current reduction step.
  assign thr = XW'(STORE_BITS) << k_r;

  // Byte index and bit position of both addresses.
  assign src_byte = BW'(src_r >> 3);
  assign dst_byte = BW'(dst_r >> 3);
  assign src_bit  = src_data[3'd7 - src_r[2:0]];
  assign mask     = 8'h80 >> dst_r[2:0];
  assign new_bit  = cmd.wr_copy ? src_bit : val_r;
  assign wr_data  = new_bit ? (dst_data | mask) : (dst_data & ~mask);

  // Next address values: a reduction step or a wrapping increment.
  always_comb begin
    src_nxt = src_r;
    dst_nxt = dst_r;
    if (cmd.reduce) begin
      if (src_r >= thr) src_nxt = src_r - thr;
      if (dst_r >= thr) dst_nxt = dst_r - thr;
    end else if (cmd.wr_copy) begin
      src_nxt = (src_r == XW'(STORE_BITS - 1)) ? '0 : src_r + XW'(1);
      dst_nxt = (dst_r == XW'(STORE_BITS - 1)) ? '0 : dst_r + XW'(1);
    end
  end

  // Request registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      src_r <= XW'(in_src_addr);
      dst_r <= XW'(in_dest_addr);
      cnt_r <= in_bit_count;
      val_r <= in_write_value;
      k_r   <= bamc_pkg::STEP_W'(K_INIT);
    end else begin
      src_r <= src_nxt;
      dst_r <= dst_nxt;
      if (cmd.reduce && k_r != '0) k_r <= k_r - 1'b1;
      if (cmd.wr_copy) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rd_bit_r <= (op_r == bamc_pkg::OP_READ) ? src_bit : 1'b0;
      rd_op_r  <= op_r;
    end
  end

  assign out_read_bit       = rd_bit_r;
  assign out_done_operation = rd_op_r;

  // Byte store: port A reads the source, port B the destination byte.
  bamc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (cmd.wr_value | cmd.wr_copy),
    .waddr  (dst_byte),
    .wdata  (wr_data),
    .ra_en  (cmd.rd_issue),
    .ra_addr(src_byte),
    .ra_data(src_data),
    .rb_en  (cmd.rd_issue),
    .rb_addr(dst_byte),
    .rb_data(dst_data)
  );

  // Status back to the controller.
  assign status.op       = op_r;
  assign status.red_last = (k_r == '0);
  assign status.cnt_zero = (cnt_r == '0);
  assign status.cnt_one  = (cnt_r == bamc_pkg::COUNT_W'(1));

endmodule

`default_nettype wire

[hw/rtl/bamc_ctrl.sv]
// ---------------------------------------------------------------------------
// bamc_ctrl
// Controller state machine: accepts a request, sequences address wrap,
// byte read or byte read-modify-write per bit and hands the result to the output slot.
// ---------------------------------------------------------------------------
`default_nettype none

module bamc_ctrl #(
  parameter int STORE_BITS = bamc_pkg::STORE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output bamc_pkg::bamc_cmd_t         cmd,
  input  wire bamc_pkg::bamc_status_t status
);

  localparam int RED_STEPS = bamc_pkg::red_steps(STORE_BITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       setup_done;

  assign slot_free  = !out_valid_r || !out_stall;
  assign setup_done = (RED_STEPS == 0) || status.red_last;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.reduce = (RED_STEPS > 0);
        if (setup_done) begin
          if (status.op == bamc_pkg::OP_READ || status.op == bamc_pkg::OP_WRITE) begin
            state_nxt = ST_ISSUE;
          end else if (status.op == bamc_pkg::OP_COPY && !status.cnt_zero) begin
            state_nxt = ST_ISSUE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = (status.op == bamc_pkg::OP_READ) ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: begin
        if (status.op == bamc_pkg::OP_COPY) begin
          cmd.wr_copy = 1'b1;
          state_nxt   = status.cnt_one ? ST_DONE : ST_ISSUE;
        end else begin
          cmd.wr_value = 1'b1;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output slot: filled on finish, emptied when the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hw/rtl/bit_addressed_memory_copy.sv]
// ---------------------------------------------------------------------------
// bit_addressed_memory_copy
// Bit addressed store with single-bit read, single-bit write and bit-run copy.
// ---------------------------------------------------------------------------
// Usage:
//   A request enters on the in_ channel (valid/stall) and carries an operation,
//   destination and source bit addresses, a bit count and a write value. Each
//   request gives exactly one result on the out_ channel: the bit read (zero
//   for other operations) and the echoed operation code.
//   Bit 0 of each stored byte is its most significant bit; all addresses wrap
//   modulo STORE_BITS. A copy moves one bit at a time in ascending order.
//   Sequence: an accept step, a setup step for the R compare-and-subtract
//   steps of the address wrap (none for STORE_BITS of 4096 and above), then
//   a byte read for a read, a byte read and write for a write, or a byte
//   read and write per copied bit (an empty copy or the unused code goes
//   straight on), then a step that loads the result; the byte read-modify-write
//   through the store sets the per-bit sequence.
//   One request is in work at a time; the next is accepted the cycle after a
//   result is loaded, even while that result still waits in the output register.
//   Reset clears the controller and the output slot; the store is not
//   cleared and holds undefined data until written.
//   While the receiver stalls, the result holds and a finished request waits
//   before its result is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module bit_addressed_memory_copy #(
  parameter int STORE_BITS = bamc_pkg::STORE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bamc_pkg::OP_W-1:0]      in_operation,
  input  wire logic [bamc_pkg::IN_ADDR_W-1:0] in_dest_addr,
  input  wire logic [bamc_pkg::IN_ADDR_W-1:0] in_src_addr,
  input  wire logic [bamc_pkg::COUNT_W-1:0]   in_bit_count,
  input  wire logic                           in_write_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_read_bit,
  output logic [bamc_pkg::OP_W-1:0]           out_done_operation
);

  bamc_pkg::bamc_cmd_t    cmd;
  bamc_pkg::bamc_status_t status;

  // Controller.
  bamc_ctrl #(
    .STORE_BITS(STORE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // Datapath and store.
  bamc_datapath #(
    .STORE_BITS(STORE_BITS)
  ) u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .status            (status),
    .in_operation      (in_operation),
    .in_dest_addr      (in_dest_addr),
    .in_src_addr       (in_src_addr),
    .in_bit_count      (in_bit_count),
    .in_write_value    (in_write_value),
    .out_read_bit      (out_read_bit),
    .out_done_operation(out_done_operation)
  );

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after accepting a request");

  // The store is never written while the block is idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_value || cmd.wr_copy) |-> in_stall)
    else $error("store written while idle");

  // A result is only loaded into a free output slot.
  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // A new result appears only after the controller finished a request.
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without a finished request");

endmodule

`default_nettype wire

[sim/bit_addressed_memory_copy_test.sv]
// ---------------------------------------------------------------------------
// bit_addressed_memory_copy_test
// Self-checking testbench for the bit addressed memory copy block. A queue of
// requests feeds a clocked driver, a clocked monitor compares every result
// against a bit-level copy of the store, and idling on both channels changes
// from phase to phase.
// ---------------------------------------------------------------------------

module bit_addressed_memory_copy_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bamc_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int STORE_BITS       = STORE_BITS_DEF;
  localparam int STORE_BYTES      = (STORE_BITS + 7) / 8;
  localparam int BYTE_W           = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int TAIL_CYCLES      = 40;
  localparam int IDLE_LIMIT       = 40000;
  localparam int MAX_REPORTS      = 200;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [IN_ADDR_W-1:0] dest;
    logic [IN_ADDR_W-1:0] src;
    logic [COUNT_W-1:0]   count;
    logic                 wval;
  } copy_request_t;

  typedef struct {
    logic            read_bit;
    logic [OP_W-1:0] op;
  } copy_result_t;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation   = OP_NONE;
  logic [IN_ADDR_W-1:0] in_dest_addr   = '0;
  logic [IN_ADDR_W-1:0] in_src_addr    = '0;
  logic [COUNT_W-1:0]   in_bit_count   = '0;
  logic                 in_write_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_read_bit;
  logic [OP_W-1:0]      out_done_operation;

  // Shadow of the store, bit 0 of each byte at the most significant position.
  logic [7:0]    shadow_bytes [STORE_BYTES];

  copy_request_t pending_q [$];
  copy_result_t  expected_q [$];
  copy_request_t driven_req;
  copy_request_t next_req;
  copy_result_t  want;

  int unsigned   queued_count     = 0;
  int unsigned   accepted_count   = 0;
  int unsigned   mismatch_count   = 0;
  int unsigned   quiet_cycles     = 0;
  int unsigned   hold_left        = 0;
  int unsigned   sender_idle_pct  = 0;
  int unsigned   recv_stall_pct   = 0;
  logic          hold_off_req     = 1'b0;
  logic          hold_off_started = 1'b0;

  bit_addressed_memory_copy #(
    .STORE_BITS(STORE_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_dest_addr      (in_dest_addr),
    .in_src_addr       (in_src_addr),
    .in_bit_count      (in_bit_count),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_bit      (out_read_bit),
    .out_done_operation(out_done_operation)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Single bit access to the shadow store.
  function automatic logic shadow_bit(input int unsigned addr);
    return shadow_bytes[BYTE_W'(addr >> 3)][3'd7 - addr[2:0]];
  endfunction

  function automatic void set_shadow_bit(input int unsigned addr, input logic value);
    shadow_bytes[BYTE_W'(addr >> 3)][3'd7 - addr[2:0]] = value;
  endfunction

  // Applies one request to the shadow store and returns the result it gives.
  // A copy steps one bit at a time in ascending order, so an overlapping copy
  // to a higher address replicates the source pattern.
  function automatic copy_result_t execute_request(input copy_request_t req);
    copy_result_t res;
    int unsigned  src;
    int unsigned  dst;
    int unsigned  left;
    res.read_bit = 1'b0;
    res.op       = req.op;
    src          = 32'(req.src) % STORE_BITS;
    dst          = 32'(req.dest) % STORE_BITS;
    left         = 32'(req.count);
    case (req.op)
      OP_READ: begin
        res.read_bit = shadow_bit(src);
      end
      OP_WRITE: begin
        set_shadow_bit(dst, req.wval);
      end
      OP_COPY: begin
        while (left != 0) begin
          set_shadow_bit(dst, shadow_bit(src));
          src  = (src + 1) % STORE_BITS;
          dst  = (dst + 1) % STORE_BITS;
          left = left - 1;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Random request; copies are mostly short, with a few long and full runs.
  function automatic copy_request_t random_request();
    copy_request_t req;
    int unsigned   pick;
    pick      = $urandom_range(0, 99);
    req.dest  = IN_ADDR_W'($urandom_range(0, STORE_BITS - 1));
    req.src   = IN_ADDR_W'($urandom_range(0, STORE_BITS - 1));
    req.count = COUNT_W'($urandom_range(0, 4096));
    req.wval  = 1'($urandom_range(0, 1));
    if (pick < 35) begin
      req.op = OP_READ;
    end else if (pick < 70) begin
      req.op = OP_WRITE;
    end else if (pick < 95) begin
      req.op = OP_COPY;
      pick   = $urandom_range(0, 99);
      if (pick < 85) begin
        req.count = COUNT_W'($urandom_range(0, 40));
      end else if (pick < 97) begin
        req.count = COUNT_W'($urandom_range(41, STORE_BITS - 1));
      end else begin
        req.count = COUNT_W'(STORE_BITS);
      end
    end else begin
      req.op = OP_NONE;
    end
    return req;
  endfunction

  task automatic queue_request(input logic [OP_W-1:0] op, input int unsigned dest,
                               input int unsigned src, input int unsigned count,
                               input logic wval);
    copy_request_t req;
    req.op    = op;
    req.dest  = IN_ADDR_W'(dest);
    req.src   = IN_ADDR_W'(src);
    req.count = COUNT_W'(count);
    req.wval  = wval;
    pending_q.push_back(req);
    queued_count++;
  endtask

  // Holds the sender back until every queued request has its result.
  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_count != queued_count || expected_q.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    // Output is capped so that a badly broken block does not flood the log.
    if (mismatch_count < MAX_REPORTS) begin
      $display("MISMATCH at %0t ns: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Request driver: holds the payload until accepted, idles at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(execute_request(driven_req));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_req       = pending_q.pop_front();
          driven_req     <= next_req;
          in_valid       <= 1'b1;
          in_operation   <= next_req.op;
          in_dest_addr   <= next_req.dest;
          in_src_addr    <= next_req.src;
          in_bit_count   <= next_req.count;
          in_write_value <= next_req.wval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall, including the one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (operation %0d)",
                                    out_done_operation));
        end else begin
          want = expected_q.pop_front();
          if (out_read_bit !== want.read_bit) begin
            report_mismatch($sformatf("read_bit %b, expected %b (operation %0d)",
                                      out_read_bit, want.read_bit, want.op));
          end
          if (out_done_operation !== want.op) begin
            report_mismatch($sformatf("done_operation %0d, expected %0d",
                                      out_done_operation, want.op));
          end
        end
      end
      if (hold_off_req && !hold_off_started) begin
        hold_off_started <= 1'b1;
        hold_left        <= HOLD_OFF_CYCLES;
        out_stall        <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("bit_addressed_memory_copy_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [7:0] seed_pattern;
    seed_pattern = 8'hB4;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Write the first byte, then fill the whole store with one overlapping
    // copy that replicates it, so that no later read touches unwritten bits.
    for (int i = 0; i < 8; i++) begin
      queue_request(OP_WRITE, i, STORE_BITS - 1 - i, (i == 0) ? 4096 : i,
                    seed_pattern[3'(7 - i)]);
    end
    queue_request(OP_COPY, 8, 0, STORE_BITS - 8, 1'b0);

    // Field extremes, wrapping copies, empty and full-length runs, the
    // unused operation code.
    queue_request(OP_READ,  4095, 0,    0,    1'b1);
    queue_request(OP_READ,  0,    4095, 4096, 1'b0);
    queue_request(OP_WRITE, 4095, 0,    0,    1'b1);
    queue_request(OP_WRITE, 0,    4095, 4096, 1'b0);
    queue_request(OP_READ,  0,    4095, 0,    1'b0);
    queue_request(OP_READ,  0,    0,    0,    1'b0);
    queue_request(OP_COPY,  100,  4090, 20,   1'b0);
    queue_request(OP_COPY,  4090, 100,  20,   1'b1);
    queue_request(OP_COPY,  9,    5,    0,    1'b0);
    queue_request(OP_COPY,  4,    3,    50,   1'b0);
    queue_request(OP_COPY,  50,   60,   30,   1'b0);
    queue_request(OP_COPY,  4095, 0,    4096, 1'b1);
    queue_request(OP_NONE,  4095, 4095, 4096, 1'b1);
    queue_request(OP_NONE,  0,    0,    0,    1'b0);
    queue_request(OP_READ,  0,    4090, 0,    1'b0);
    queue_request(OP_READ,  0,    4095, 0,    1'b0);
    queue_request(OP_READ,  0,    30,   0,    1'b0);
    wait_drained();

    // Random phases: none, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct <= (phase == 1) ? 57 : (phase == 3) ? 10 : 0;
      recv_stall_pct  <= (phase == 2) ? 57 : (phase == 3) ? 10 : 0;
      // The long hold-off lands while the sender offers back-to-back requests.
      if (phase == 0) begin
        hold_off_req <= 1'b1;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_q.push_back(random_request());
        queued_count++;
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bit_addressed_memory_copy_test passed");
    end else begin
      $display("bit_addressed_memory_copy_test failed");
    end
    $finish;
  end

endmodule
